// ----- src/cra_pkg.sv -----
// Shared types and constants for the command retry/ack table.
// Used by the channel interfaces, the controller, the datapath and the top level.
// Depends on nothing.
package cra_pkg;

  typedef enum logic [1:0] {
    CMD_SEND = 2'd0,
    CMD_ACK  = 2'd1,
    CMD_TICK = 2'd2
  } command_t;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_EVAL,
    ST_WAIT_SCAN,
    ST_FINISH,
    ST_WAIT_DONE
  } state_t;

  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned NRES_W = 5;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [7:0] ACK_RESULT_OK = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_DELAY = 8'd1;
  localparam logic [7:0] MAX_RETRIES_RST = 8'd3;
  localparam logic [15:0] RETRY_DELAY_RST = 16'd1000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  accept;
    logic  send_write;
    logic  tick_inc;
    logic  scan_init;
    logic  scan_step;
    logic  resend;
    logic  remove;
    logic  record;
    kind_t rec_kind;
    logic  rec_from_item;
    logic  rec_acc;
    logic  final_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_send;
    logic is_ack;
    logic is_tick;
    logic full;
    logic idx_zero;
    logic cap_hit;
    logic id_match;
    logic due;
    logic has_retries;
    logic res_ok;
    logic pend_valid;
    logic out_fire;
  } dp_stat_t;

endpackage

// ----- src/cra_if.sv -----
// Valid/ready channel interfaces for the command retry/ack table.
// Depends on cra_pkg for the configuration port widths.
interface cra_in_if #(parameter int TAG_WIDTH = 8);
  logic                 valid;
  logic                 ready;
  logic [1:0]           command;
  logic [15:0]          command_id;
  logic [TAG_WIDTH-1:0] msg_tag;
  logic [7:0]           ack_result;
  modport source(output valid, command, command_id, msg_tag, ack_result, input ready);
  modport sink(input valid, command, command_id, msg_tag, ack_result, output ready);
endinterface

interface cra_out_if #(parameter int TAG_WIDTH = 8);
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic [15:0]          out_command_id;
  logic [TAG_WIDTH-1:0] out_msg_tag;
  logic                 accepted;
  logic                 last;
  modport source(output valid, kind, out_command_id, out_msg_tag, accepted, last,
                 input ready);
  modport sink(input valid, kind, out_command_id, out_msg_tag, accepted, last,
               output ready);
endinterface

interface cra_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cra_pkg::CFG_IDX_W-1:0]   index;
  logic [cra_pkg::CFG_DATA_W-1:0]  data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- src/cra_ctrl.sv -----
// Controller state machine of the command retry/ack table.
// Depends on cra_pkg; drives dp_cmd_t to cra_dp and reads dp_stat_t back.
module cra_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cra_pkg::dp_stat_t  stat,
  output cra_pkg::dp_cmd_t   cmd,
  output cra_pkg::state_t    state
);

  cra_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cra_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.rec_kind = cra_pkg::KIND_TX;
    in_ready = 1'b0;
    unique case (state)
      cra_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = cra_pkg::ST_DISPATCH;
        end
      end
      cra_pkg::ST_DISPATCH: begin
        if (stat.is_send) begin
          cmd.record = 1'b1;
          cmd.rec_from_item = 1'b1;
          if (stat.full) begin
            cmd.rec_kind = cra_pkg::KIND_REJECT;
          end else begin
            cmd.send_write = 1'b1;
          end
          state_next = cra_pkg::ST_FINISH;
        end else if (stat.is_ack) begin
          cmd.scan_init = 1'b1;
          state_next = cra_pkg::ST_SCAN;
        end else if (stat.is_tick) begin
          cmd.tick_inc = 1'b1;
          cmd.scan_init = 1'b1;
          state_next = cra_pkg::ST_SCAN;
        end else begin
          state_next = cra_pkg::ST_IDLE;
        end
      end
      cra_pkg::ST_SCAN: begin
        if (stat.idx_zero || (stat.is_tick && stat.cap_hit)) begin
          state_next = cra_pkg::ST_FINISH;
        end else begin
          cmd.scan_step = 1'b1;
          state_next = cra_pkg::ST_EVAL;
        end
      end
      cra_pkg::ST_EVAL: begin
        state_next = cra_pkg::ST_SCAN;
        if (stat.is_ack) begin
          if (stat.id_match) begin
            cmd.record = 1'b1;
            cmd.rec_kind = cra_pkg::KIND_DONE;
            cmd.rec_acc = stat.res_ok;
            cmd.remove = 1'b1;
            state_next = cra_pkg::ST_FINISH;
          end
        end else if (stat.due) begin
          cmd.record = 1'b1;
          if (stat.has_retries) begin
            cmd.resend = 1'b1;
          end else begin
            cmd.rec_kind = cra_pkg::KIND_DONE;
            cmd.remove = 1'b1;
          end
          // An earlier result goes out now that it is known not to be the last.
          if (stat.pend_valid) begin
            state_next = cra_pkg::ST_WAIT_SCAN;
          end
        end
      end
      cra_pkg::ST_WAIT_SCAN: begin
        if (stat.out_fire) begin
          state_next = cra_pkg::ST_SCAN;
        end
      end
      cra_pkg::ST_FINISH: begin
        if (stat.pend_valid) begin
          cmd.final_out = 1'b1;
          state_next = cra_pkg::ST_WAIT_DONE;
        end else begin
          state_next = cra_pkg::ST_IDLE;
        end
      end
      cra_pkg::ST_WAIT_DONE: begin
        if (stat.out_fire) begin
          state_next = cra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cra_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/cra_dp.sv -----
// Datapath of the command retry/ack table: entry memory, order list, time,
// configuration registers and result registers. Depends on cra_pkg.
module cra_dp #(
  parameter int TABLE_DEPTH = 16,
  parameter int TAG_WIDTH   = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [1:0]                         in_command,
  input  logic [15:0]                        in_command_id,
  input  logic [TAG_WIDTH-1:0]               in_msg_tag,
  input  logic [7:0]                         in_ack_result,
  input  logic                               cfg_we,
  input  logic [cra_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cra_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [1:0]                         out_kind,
  output logic [15:0]                        out_id,
  output logic [TAG_WIDTH-1:0]               out_tag,
  output logic                               out_acc,
  output logic                               out_last,
  input  cra_pkg::dp_cmd_t                   cmd,
  output cra_pkg::dp_stat_t                  stat
);

  localparam int SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [7:0]           max_retries;
  logic [15:0]          retry_delay;
  logic [31:0]          time_now;
  logic [CW-1:0]        count;
  logic [CW-1:0]        idx;
  logic [cra_pkg::NRES_W-1:0] nres;

  logic [1:0]           item_cmd;
  logic [15:0]          item_id;
  logic [TAG_WIDTH-1:0] item_tag;
  logic [7:0]           item_res;

  // Position in age order -> memory slot. Slots beyond the count are free.
  logic [SW-1:0]        pos [TABLE_DEPTH];

  logic [15:0]          mem_id  [TABLE_DEPTH];
  logic [TAG_WIDTH-1:0] mem_tag [TABLE_DEPTH];
  logic [7:0]           mem_ret [TABLE_DEPTH];
  logic [31:0]          mem_dl  [TABLE_DEPTH];

  logic [15:0]          rd_id;
  logic [TAG_WIDTH-1:0] rd_tag;
  logic [7:0]           rd_ret;
  logic [31:0]          rd_dl;

  logic [1:0]           pend_kind;
  logic [15:0]          pend_id;
  logic [TAG_WIDTH-1:0] pend_tag;
  logic                 pend_acc;
  logic                 pend_valid;

  logic [CW-1:0]        idx_dec;
  logic [SW-1:0]        wr_addr;
  logic                 wr_en;
  logic [15:0]          wr_id;
  logic [TAG_WIDTH-1:0] wr_tag;
  logic [7:0]           wr_ret;
  logic [31:0]          fresh_dl;
  logic [31:0]          age;
  logic [15:0]          rec_id;
  logic [TAG_WIDTH-1:0] rec_tag;

  assign idx_dec  = idx - CW'(1);
  assign fresh_dl = time_now + 32'(retry_delay);
  assign age      = time_now - rd_dl;
  assign wr_en    = cmd.send_write | cmd.resend;
  assign wr_addr  = cmd.send_write ? pos[count[SW-1:0]] : pos[idx[SW-1:0]];
  assign wr_id    = cmd.send_write ? item_id : rd_id;
  assign wr_tag   = cmd.send_write ? item_tag : rd_tag;
  assign wr_ret   = cmd.send_write ? max_retries : rd_ret - 8'd1;
  assign rec_id   = cmd.rec_from_item ? item_id : rd_id;
  assign rec_tag  = cmd.rec_from_item ? item_tag : rd_tag;

  always_comb begin
    stat.is_send     = (item_cmd == cra_pkg::CMD_SEND);
    stat.is_ack      = (item_cmd == cra_pkg::CMD_ACK);
    stat.is_tick     = (item_cmd == cra_pkg::CMD_TICK);
    stat.full        = (count == CW'(TABLE_DEPTH));
    stat.idx_zero    = (idx == '0);
    stat.cap_hit     = (nres == cra_pkg::NRES_W'(cra_pkg::MAX_RESULTS));
    stat.id_match    = (rd_id == item_id);
    stat.due         = ~age[31];
    stat.has_retries = (rd_ret != 8'd0);
    stat.res_ok      = (item_res == cra_pkg::ACK_RESULT_OK);
    stat.pend_valid  = pend_valid;
    stat.out_fire    = out_valid & out_ready;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_id[wr_addr]  <= wr_id;
      mem_tag[wr_addr] <= wr_tag;
      mem_ret[wr_addr] <= wr_ret;
      mem_dl[wr_addr]  <= fresh_dl;
    end
    if (cmd.scan_step) begin
      rd_id  <= mem_id[pos[idx_dec[SW-1:0]]];
      rd_tag <= mem_tag[pos[idx_dec[SW-1:0]]];
      rd_ret <= mem_ret[pos[idx_dec[SW-1:0]]];
      rd_dl  <= mem_dl[pos[idx_dec[SW-1:0]]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_cmd <= in_command;
      item_id  <= in_command_id;
      item_tag <= in_msg_tag;
      item_res <= in_ack_result;
    end
    if (cmd.scan_init) begin
      idx <= count;
    end else if (cmd.scan_step) begin
      idx <= idx_dec;
    end
    if (cmd.record) begin
      pend_kind <= cmd.rec_kind;
      pend_id   <= rec_id;
      pend_tag  <= rec_tag;
      pend_acc  <= cmd.rec_acc;
    end
    if ((cmd.record && pend_valid) || cmd.final_out) begin
      out_kind <= pend_kind;
      out_id   <= pend_id;
      out_tag  <= pend_tag;
      out_acc  <= pend_acc;
      out_last <= cmd.final_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_retries <= cra_pkg::MAX_RETRIES_RST;
      retry_delay <= cra_pkg::RETRY_DELAY_RST;
      time_now    <= '0;
      count       <= '0;
      nres        <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
      for (int j = 0; j < TABLE_DEPTH; j++) begin
        pos[j] <= SW'(j);
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cra_pkg::REG_MAX_RETRIES: max_retries <= cfg_data[7:0];
          cra_pkg::REG_RETRY_DELAY: retry_delay <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.tick_inc) begin
        time_now <= time_now + 32'd1;
      end
      if (cmd.accept) begin
        nres <= '0;
      end else if (cmd.record) begin
        nres <= nres + cra_pkg::NRES_W'(1);
      end
      if (cmd.send_write) begin
        count <= count + CW'(1);
      end else if (cmd.remove) begin
        count <= count - CW'(1);
        // Close the gap and park the freed slot at the tail of the list.
        for (int j = 0; j < TABLE_DEPTH - 1; j++) begin
          if (CW'(j) >= idx) begin
            pos[j] <= pos[j + 1];
          end
        end
        pos[TABLE_DEPTH-1] <= pos[idx[SW-1:0]];
      end
      if (cmd.record) begin
        pend_valid <= 1'b1;
      end else if (cmd.final_out) begin
        pend_valid <= 1'b0;
      end
      if ((cmd.record && pend_valid) || cmd.final_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- src/command_retry_ack_table.sv -----
// Top level of the command retry/ack table.
// Depends on cra_pkg, cra_if.sv, cra_ctrl and cra_dp.
//
// Usage:
//   req carries one word per item: command (send, ack or tick), command_id,
//   msg_tag and ack_result. rsp carries result words: kind, out_command_id,
//   out_msg_tag, accepted and last, which marks the final result of an item.
//   cfg writes max_retries (index 0) and retry_delay (index 1); it is always
//   ready and should be used only while the block is idle.
// Timing:
//   One item is processed at a time; req.ready is high only when idle.
//   A send's result is recorded in the dispatch state and its word is made
//   valid from the finish state. An ack or tick walks the table from newest
//   to oldest; each entry passes a scan state (registered entry memory read
//   through the order list) and an evaluate state. An ack stops at its
//   matching entry and a tick stops once the result cap is hit. Input
//   reopens in the cycle after the last word is taken.
//   Each result is held until taken; while rsp.ready is low the scan waits.
// Reset:
//   rst empties the table, clears the tick counter and restores max_retries
//   to 3 and retry_delay to 1000. No clearing pass is needed.
module command_retry_ack_table #(
  parameter int TABLE_DEPTH = 16,
  parameter int TAG_WIDTH   = 8
) (
  input logic clk,
  input logic rst,
  cra_in_if.sink   req,
  cra_out_if.source rsp,
  cra_cfg_if.sink  cfg
);

  cra_pkg::dp_cmd_t  dcmd;
  cra_pkg::dp_stat_t dstat;
  cra_pkg::state_t   state;
  logic              in_ready;
  logic [1:0]        out_kind;

  assign req.ready = in_ready;
  assign cfg.ready = 1'b1;
  assign rsp.kind  = out_kind;

  cra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (dstat),
    .cmd      (dcmd),
    .state    (state)
  );

  cra_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TAG_WIDTH   (TAG_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .in_command    (req.command),
    .in_command_id (req.command_id),
    .in_msg_tag    (req.msg_tag),
    .in_ack_result (req.ack_result),
    .cfg_we        (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .out_ready     (rsp.ready),
    .out_valid     (rsp.valid),
    .out_kind      (out_kind),
    .out_id        (rsp.out_command_id),
    .out_tag       (rsp.out_msg_tag),
    .out_acc       (rsp.accepted),
    .out_last      (rsp.last),
    .cmd           (dcmd),
    .stat          (dstat)
  );

  // A result word is never shown while a new item can be taken.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready)
    else $error("result word pending while input is ready");

  // After an item is taken, input is closed in the following cycle.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second item taken back to back");

  // No result is left pending once the block is idle.
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == cra_pkg::ST_IDLE) |-> !dstat.pend_valid)
    else $error("pending result left in idle");

endmodule
